// ===== src/addressable_led_frame_driver_assert.svh =====
// Assertion macros for the checker file of the LED frame driver.
`ifndef ADDRESSABLE_LED_FRAME_DRIVER_ASSERT_SVH
`define ADDRESSABLE_LED_FRAME_DRIVER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ALFD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("alfd: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define ALFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("alfd: next-cycle check failed");

`endif

// ===== src/alfd_pkg.sv =====
// Shared constants and register codes of the LED frame driver.
package alfd_pkg;

  // default number of LEDs on the strip
  localparam int LED_COUNT_DEF = 20;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 2'd2;

  // register reset values
  localparam logic [7:0] ZERO_HIGH_RST  = 8'd3;
  localparam logic [7:0] ONE_HIGH_RST   = 8'd6;
  localparam logic [7:0] BIT_PERIOD_RST = 8'd10;

endpackage

// ===== src/addressable_led_frame_driver.sv =====
// Top level of the LED frame driver: frame receive, pulse timing and buffer control.
//
// Each input transfer is either a received byte (tuser kind 0) or one timing tick
// (kind 1) and produces exactly one status result. A new item is taken
// whenever the output register is free or being drained.
// While a frame is sent, every byte boundary (and the start of the frame) holds the
// input off for the frame buffer's registered read and then for the load of the shift
// register. The frame buffer holds 3*LED_COUNT bytes in a single memory.
// Configuration writes are always accepted and take effect at once.
module addressable_led_frame_driver #(
  parameter int LED_COUNT = alfd_pkg::LED_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
  input  logic [0:0]                     s_tuser,   // [0] kind
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [0] line_level, [1] sending,
                                                    // [2] byte_dropped, [3] frame_done,
                                                    // [7:4] zero
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [alfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  localparam int FRAME_MAX = LED_COUNT * 3;
  localparam int AW = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
  localparam logic [7:0] FRAME_MAX_B = 8'(FRAME_MAX);

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_RECV,
    PH_SEND,
    PH_RD,
    PH_LD
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] bytes_received, bytes_received_next;
  logic [7:0] send_index, send_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [2:0] bit_count, bit_count_next;
  logic [7:0] tick_count, tick_count_next;

  logic [7:0] zero_high_ticks, one_high_ticks, bit_period_ticks;

  logic       in_accept;
  logic       res_level, res_sending, res_dropped, res_done;

  logic       wr_en, rd_en;
  logic [7:0] rd_data;

  logic [7:0] len_clamped, br_inc, tick_inc, send_inc, high_ticks;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_high_ticks  <= alfd_pkg::ZERO_HIGH_RST;
      one_high_ticks   <= alfd_pkg::ONE_HIGH_RST;
      bit_period_ticks <= alfd_pkg::BIT_PERIOD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        alfd_pkg::REG_ZERO_HIGH:  zero_high_ticks  <= cfg_data;
        alfd_pkg::REG_ONE_HIGH:   one_high_ticks   <= cfg_data;
        alfd_pkg::REG_BIT_PERIOD: bit_period_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // input is taken only in working phases and when the result slot frees up
  assign s_tready  = (phase == PH_WAIT || phase == PH_RECV || phase == PH_SEND) &&
                     (!m_tvalid || m_tready);
  assign in_accept = s_tvalid && s_tready;

  assign len_clamped = (s_tdata > FRAME_MAX_B) ? FRAME_MAX_B : s_tdata;
  assign br_inc      = bytes_received + 8'd1;
  assign tick_inc    = tick_count + 8'd1;
  assign send_inc    = send_index + 8'd1;
  assign high_ticks  = shift_byte[7] ? one_high_ticks : zero_high_ticks;

  // frame buffer
  assign wr_en = in_accept && !s_tuser[0] && (phase == PH_RECV);
  assign rd_en = (phase == PH_RD);

  alfd_frame_mem #(
    .DEPTH (FRAME_MAX),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (bytes_received[AW-1:0]),
    .wr_data (s_tdata),
    .rd_en   (rd_en),
    .rd_addr (send_index[AW-1:0]),
    .rd_data (rd_data)
  );

  // next state and result of the accepted item
  always_comb begin
    phase_next          = phase;
    frame_length_next   = frame_length;
    bytes_received_next = bytes_received;
    send_index_next     = send_index;
    shift_byte_next     = shift_byte;
    bit_count_next      = bit_count;
    tick_count_next     = tick_count;
    res_level           = 1'b0;
    res_dropped         = 1'b0;
    res_done            = 1'b0;
    case (phase)
      PH_WAIT: begin
        if (in_accept && !s_tuser[0]) begin
          frame_length_next   = len_clamped;
          bytes_received_next = 8'd0;
          if (len_clamped != 8'd0) begin
            phase_next = PH_RECV;
          end
        end
      end
      PH_RECV: begin
        if (in_accept && !s_tuser[0]) begin
          bytes_received_next = br_inc;
          if (br_inc >= frame_length) begin
            phase_next      = PH_RD;
            send_index_next = 8'd0;
            bit_count_next  = 3'd0;
            tick_count_next = 8'd0;
          end
        end
      end
      PH_SEND: begin
        if (in_accept) begin
          if (!s_tuser[0]) begin
            res_dropped = 1'b1;
          end else begin
            res_level       = (tick_count < high_ticks);
            tick_count_next = tick_inc;
            if (tick_inc >= bit_period_ticks) begin
              tick_count_next = 8'd0;
              shift_byte_next = {shift_byte[6:0], 1'b0};
              if (bit_count == 3'd7) begin
                bit_count_next  = 3'd0;
                send_index_next = send_inc;
                if (send_inc >= frame_length) begin
                  phase_next = PH_WAIT;
                  res_done   = 1'b1;
                end else begin
                  phase_next = PH_RD;
                end
              end else begin
                bit_count_next = bit_count + 3'd1;
              end
            end
          end
        end
      end
      PH_RD: begin
        phase_next = PH_LD;
      end
      PH_LD: begin
        shift_byte_next = rd_data;
        phase_next      = PH_SEND;
      end
      default: begin
        phase_next = PH_WAIT;
      end
    endcase
    res_sending = (phase_next == PH_SEND || phase_next == PH_RD || phase_next == PH_LD);
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_WAIT;
      frame_length   <= 8'd0;
      bytes_received <= 8'd0;
      send_index     <= 8'd0;
      shift_byte     <= 8'd0;
      bit_count      <= 3'd0;
      tick_count     <= 8'd0;
      m_tvalid       <= 1'b0;
      m_tdata        <= 8'd0;
    end else begin
      phase          <= phase_next;
      frame_length   <= frame_length_next;
      bytes_received <= bytes_received_next;
      send_index     <= send_index_next;
      shift_byte     <= shift_byte_next;
      bit_count      <= bit_count_next;
      tick_count     <= tick_count_next;
      if (in_accept) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {4'd0, res_done, res_dropped, res_sending, res_level};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/alfd_frame_mem.sv =====
// Frame buffer: one write port, one read port with registered read data.
module alfd_frame_mem #(
  parameter int DEPTH = 60,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/alfd_checker.sv =====
// Port-level checks of the LED frame driver, bound to the top level.
`include "addressable_led_frame_driver_assert.svh"

module alfd_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // stalled result stays offered and unchanged
  `ALFD_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
  `ALFD_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))

  // frame end leaves the sending state
  `ALFD_ASSERT_SAME(a_done_idle, m_tvalid && m_tdata[3], !m_tdata[1])

  // a byte is dropped only while a frame goes out
  `ALFD_ASSERT_SAME(a_drop_sending, m_tvalid && m_tdata[2], m_tdata[1])

  // the line is driven high only during a bit period of a frame
  `ALFD_ASSERT_SAME(a_level_in_frame, m_tvalid && m_tdata[0], m_tdata[1] || m_tdata[3])

endmodule

bind addressable_led_frame_driver alfd_checker u_alfd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the addressable LED frame driver: framing, pulse timing, drops.
module tb;

  localparam int LED_COUNT = alfd_pkg::LED_COUNT_DEF;
  localparam int FRAME_BYTES = 3 * LED_COUNT;
  localparam logic [7:0] FRAME_LEN_MAX = 8'(FRAME_BYTES);
  localparam logic [alfd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 20;

  typedef enum logic [1:0] {WAIT_LEN, RECV_DATA, SEND_BITS} frame_phase_t;

  // Predicts the status word of every transfer and checks the block's results
  class led_frame_scoreboard;
    logic [7:0] zero_high, one_high, period_len;
    frame_phase_t phase;
    logic [7:0] frame_len, rx_count, send_idx, shift_reg, tick_cnt;
    logic [2:0] bit_idx;
    logic [7:0] frame_mem [FRAME_BYTES];
    logic [7:0] expected_status [$];
    int errors;

    function new();
      zero_high = alfd_pkg::ZERO_HIGH_RST;
      one_high = alfd_pkg::ONE_HIGH_RST;
      period_len = alfd_pkg::BIT_PERIOD_RST;
      phase = WAIT_LEN;
      frame_len = 0;
      rx_count = 0;
      send_idx = 0;
      shift_reg = 0;
      tick_cnt = 0;
      bit_idx = 0;
      foreach (frame_mem[i]) frame_mem[i] = 8'h00;
      errors = 0;
    endfunction

    function void write_reg(logic [alfd_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        alfd_pkg::REG_ZERO_HIGH:  zero_high = val;
        alfd_pkg::REG_ONE_HIGH:   one_high = val;
        alfd_pkg::REG_BIT_PERIOD: period_len = val;
        default: ;  // unused index, write has no effect
      endcase
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    // Advance the frame state by one accepted input transfer
    function void note_input(logic kind, logic [7:0] data);
      logic level, dropped, done;
      logic [7:0] high;
      level = 1'b0;
      dropped = 1'b0;
      done = 1'b0;
      if (kind == KIND_BYTE) begin
        case (phase)
          SEND_BITS: dropped = 1'b1;
          RECV_DATA: begin
            if (rx_count < FRAME_BYTES) frame_mem[rx_count] = data;
            rx_count++;
            // last payload byte starts the frame output
            if (rx_count >= frame_len) begin
              phase = SEND_BITS;
              send_idx = 0;
              shift_reg = frame_mem[0];
              bit_idx = 0;
              tick_cnt = 0;
            end
          end
          default: begin
            frame_len = (data > FRAME_LEN_MAX) ? FRAME_LEN_MAX : data;
            rx_count = 0;
            if (frame_len != 0) phase = RECV_DATA;
          end
        endcase
      end else if (phase == SEND_BITS) begin
        high = shift_reg[7] ? one_high : zero_high;
        level = (tick_cnt < high);
        tick_cnt++;
        // end of one bit period
        if (tick_cnt >= period_len) begin
          tick_cnt = 0;
          shift_reg = shift_reg << 1;
          if (bit_idx == 3'd7) begin
            bit_idx = 0;
            send_idx++;
            if (send_idx >= frame_len) begin
              phase = WAIT_LEN;
              done = 1'b1;
            end else begin
              shift_reg = frame_mem[send_idx];
            end
          end else begin
            bit_idx++;
          end
        end
      end
      expected_status.push_back({4'b0000, done, dropped, phase == SEND_BITS, level});
    endfunction

    function void check_result(logic [7:0] got);
      logic [7:0] want;
      string field;
      if (expected_status.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %02h", $time, got);
        return;
      end
      want = expected_status.pop_front();
      for (int b = 0; b < 4; b++) begin
        case (b)
          0: field = "line_level";
          1: field = "sending";
          2: field = "byte_dropped";
          default: field = "frame_done";
        endcase
        if (got[b] !== want[b]) begin
          errors++;
          $display("%0t: %s mismatch, expected %0b, got %0b", $time, field, want[b], got[b]);
        end
      end
      if (got[7:4] !== 4'h0) begin
        errors++;
        $display("%0t: pad bits mismatch, expected 0, got %0h", $time, got[7:4]);
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic [0:0] s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [alfd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = 8'h00;

  led_frame_scoreboard sb;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_sent = 0;
  int stall_cycles = 0;

  addressable_led_frame_driver #(.LED_COUNT(LED_COUNT)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result-side backpressure
  always @(negedge clk) m_tready <= ($urandom_range(99) >= rx_idle_pct);

  // Observe every transfer at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (s_tvalid && s_tready) sb.note_input(s_tuser[0], s_tdata);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // One input transfer; tvalid stays high on return for a back-to-back item
  task automatic send_item(logic kind, logic [7:0] data);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= data;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // Hold off input until every result is back, then let the block settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write all timing registers plus the unused index
  task automatic program_timing(logic [7:0] zero_t, logic [7:0] one_t, logic [7:0] period_t);
    logic [alfd_pkg::CFG_IDX_W-1:0] idx [4];
    logic [7:0] val [4];
    idx[0] = alfd_pkg::REG_ZERO_HIGH;
    idx[1] = alfd_pkg::REG_ONE_HIGH;
    idx[2] = alfd_pkg::REG_BIT_PERIOD;
    idx[3] = REG_UNUSED;
    val[0] = zero_t;
    val[1] = one_t;
    val[2] = period_t;
    val[3] = 8'($urandom_range(255));
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Feed payload bytes and ticks until the predicted frame has gone out
  task automatic finish_frame();
    logic [7:0] fill;
    while (sb.phase != WAIT_LEN) begin
      if (sb.phase == RECV_DATA) begin
        case ($urandom_range(3))
          0: fill = 8'h00;
          1: fill = 8'hFF;
          default: fill = 8'($urandom_range(255));
        endcase
        // occasional tick in the middle of the payload is ignored
        if ($urandom_range(15) == 0) send_item(KIND_TICK, 8'($urandom_range(255)));
        else send_item(KIND_BYTE, fill);
      end else if ($urandom_range(31) == 0) begin
        send_item(KIND_BYTE, 8'($urandom_range(255)));
      end else begin
        send_item(KIND_TICK, 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic send_frame(logic [7:0] len_byte);
    send_item(KIND_BYTE, len_byte);
    finish_frame();
  endtask

  // Mostly short well-formed frames, some noise and cut-up sequences
  task automatic random_traffic(int n);
    int first_item;
    first_item = items_sent;
    while (items_sent - first_item < n) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(1) == 1) send_item(KIND_TICK, 8'($urandom_range(255)));
          else if (sb.phase == WAIT_LEN) send_item(KIND_BYTE, 8'($urandom_range(4)));
          else send_item(KIND_BYTE, 8'($urandom_range(255)));
        end
        finish_frame();
      end else if ($urandom_range(19) == 0) begin
        send_frame(8'($urandom_range(5, 12)));
      end else begin
        send_frame(8'($urandom_range(4)));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // sender idles often, receiver very often
    tx_idle_pct = 38;
    rx_idle_pct = 87;

    // reset timing: idle tick, zero length, one-byte frame with a drop
    send_item(KIND_TICK, 8'hFF);
    send_frame(8'h00);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_BYTE, 8'h01);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_BYTE, 8'hA5);
    send_item(KIND_BYTE, 8'h5A);
    finish_frame();
    wait_idle();

    // zero bits never high, one bits high through the whole period
    program_timing(8'd0, 8'd255, 8'd3);
    send_frame(8'd1);
    wait_idle();

    // zero bits high all period, one bits low, one tick per bit
    program_timing(8'd255, 8'd0, 8'd1);
    send_frame(8'd2);
    random_traffic(RANDOM_ITEMS / 3);
    wait_idle();

    // other way round
    tx_idle_pct = 87;
    rx_idle_pct = 38;

    repeat (2) begin
      program_timing(8'($urandom_range(4)), 8'($urandom_range(4)), 8'($urandom_range(3)));
      random_traffic(RANDOM_ITEMS);
      wait_idle();
    end

    // no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (3) begin
      program_timing(8'($urandom_range(4)), 8'($urandom_range(4)), 8'($urandom_range(3)));
      random_traffic(RANDOM_ITEMS);
      wait_idle();
    end

    // period zero and an oversized length clamped to the buffer size;
    // the full buffer starts going out, first bytes only
    program_timing(8'd1, 8'd0, 8'd0);
    send_item(KIND_BYTE, 8'd255);
    repeat (FRAME_BYTES) send_item(KIND_BYTE, 8'($urandom_range(255)));
    repeat (8) send_item(KIND_TICK, 8'h00);
    send_item(KIND_BYTE, 8'h3C);
    repeat (8) send_item(KIND_TICK, 8'h00);
    wait_idle();

    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
